// File: rtl/fwpr_pkg.sv
// fwpr_pkg: request and response types, command and status codes for the
// prefix-reverse queue. No dependencies.
`default_nettype none

package fwpr_pkg;

    localparam int OPC_W   = 2;
    localparam int DATA_W  = 32;
    localparam int K_W     = 5;
    localparam int OCC_W   = 5;
    localparam int STS_W   = 2;
    localparam int SWAP_W  = K_W - 1;

    localparam logic [OPC_W-1:0] OP_PUSH    = 2'd0;
    localparam logic [OPC_W-1:0] OP_POP     = 2'd1;
    localparam logic [OPC_W-1:0] OP_REVERSE = 2'd2;

    localparam logic [STS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STS_W-1:0] ST_FULL        = 2'd1;
    localparam logic [STS_W-1:0] ST_EMPTY       = 2'd2;
    localparam logic [STS_W-1:0] ST_REV_IGNORED = 2'd3;

    typedef struct packed {
        logic [OPC_W-1:0]         opcode;
        logic signed [DATA_W-1:0] push_value;
        logic [K_W-1:0]           reverse_count;
    } fwpr_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        logic [STS_W-1:0]         status;
        logic [OCC_W-1:0]         occupancy;
    } fwpr_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_RD,
        S_SW_RD,
        S_SW_WR1,
        S_SW_WR2,
        S_RESP
    } fwpr_state_t;

endpackage

`default_nettype wire

// File: rtl/fifo_with_prefix_reverse_unit.sv
// fifo_with_prefix_reverse_unit: circular queue of signed words in one
// synchronous memory, with push, pop and in-place reversal of the oldest k.
// Depends on fwpr_pkg.
//
//  channel | signals                       | direction
//  --------+-------------------------------+----------
//  request | in_valid, in_stall, in_data   | in
//  result  | out_valid, out_stall, out_data| out
//
// One request at a time. Push, rejected commands and the unused opcode go
// from S_IDLE to S_RESP, pop through S_POP_RD, and a reverse of k entries
// runs floor(k/2) swaps, each read, write, write on the memory's single write port.
// A result waits in the output register while the next request is taken.
// Reset clears the indices and the count; memory contents are left as is.
`default_nettype none

module fifo_with_prefix_reverse_unit
    import fwpr_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire fwpr_req_t in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output fwpr_rsp_t      out_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_array [DEPTH];

    fwpr_state_t       state_reg, state_next;
    logic [IW-1:0]     head_reg, head_next;
    logic [IW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     lo_reg, lo_next;
    logic [IW-1:0]     hi_reg, hi_next;
    logic [SWAP_W-1:0] swaps_left_reg, swaps_left_next;
    logic [DATA_W-1:0] swap_reg, swap_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    logic [STS_W-1:0]  res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    fwpr_rsp_t         out_data_reg, out_data_next;

    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [IW-1:0]     mem_raddr_a;
    logic [IW-1:0]     mem_raddr_b;
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;

    logic              accept;
    logic              is_full;
    logic              is_empty;

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                               input logic [IW:0]   off);
        logic [IW:0] s;
        s = {1'b0, base} + off;
        if (s >= (IW+1)'(DEPTH))
        begin
            s = s - (IW+1)'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] idx);
        logic [IW-1:0] r;
        if (idx == '0)
        begin
            r = IW'(DEPTH - 1);
        end
        else
        begin
            r = idx - IW'(1);
        end
        return r;
    endfunction

    assign accept    = in_valid && !in_stall;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        swaps_left_next = swaps_left_reg;
        swap_next       = swap_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = tail_reg;
        mem_wdata       = in_data.push_value;
        mem_re          = 1'b0;
        mem_raddr_a     = head_reg;
        mem_raddr_b     = hi_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_value_next  = '0;
                    res_status_next = ST_OK;
                    state_next      = S_RESP;
                    unique case (in_data.opcode)
                        OP_PUSH:
                        begin
                            if (is_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                tail_next  = wrap_add(tail_reg, (IW+1)'(1));
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                head_next  = wrap_add(head_reg, (IW+1)'(1));
                                count_next = count_reg - CW'(1);
                                state_next = S_POP_RD;
                            end
                        end
                        OP_REVERSE:
                        begin
                            if (is_empty || in_data.reverse_count == '0 ||
                                32'(in_data.reverse_count) > 32'(count_reg))
                            begin
                                res_status_next = ST_REV_IGNORED;
                            end
                            else if (in_data.reverse_count[K_W-1:1] != '0)
                            begin
                                lo_next         = head_reg;
                                hi_next         = wrap_add(head_reg,
                                    (IW+1)'(in_data.reverse_count - K_W'(1)));
                                swaps_left_next = in_data.reverse_count[K_W-1:1];
                                state_next      = S_SW_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP_RD:
            begin
                res_value_next = rd_a_reg;
                state_next     = S_RESP;
            end
            S_SW_RD:
            begin
                mem_re      = 1'b1;
                mem_raddr_a = lo_reg;
                mem_raddr_b = hi_reg;
                state_next  = S_SW_WR1;
            end
            S_SW_WR1:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lo_reg;
                mem_wdata  = rd_b_reg;
                swap_next  = rd_a_reg;
                state_next = S_SW_WR2;
            end
            S_SW_WR2:
            begin
                mem_we          = 1'b1;
                mem_waddr       = hi_reg;
                mem_wdata       = swap_reg;
                lo_next         = wrap_add(lo_reg, (IW+1)'(1));
                hi_next         = wrap_dec(hi_reg);
                swaps_left_next = swaps_left_reg - SWAP_W'(1);
                if (swaps_left_reg == SWAP_W'(1))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_SW_RD;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.pop_value = res_value_reg;
                    out_data_next.status    = res_status_reg;
                    out_data_next.occupancy = OCC_W'(count_reg);
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_a_reg <= mem_array[mem_raddr_a];
            rd_b_reg <= mem_array[mem_raddr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        swaps_left_reg <= swaps_left_next;
        swap_reg       <= swap_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CW'(DEPTH)) |-> head_reg == tail_reg)
        else $error("head and tail disagree with count");

    a_swap_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SW_WR2 |-> swaps_left_reg != '0)
        else $error("swap issued with none outstanding");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SW_RD || state_reg == S_SW_WR1 || state_reg == S_SW_WR2)
        |=> $stable(count_reg) && $stable(head_reg))
        else $error("queue bounds moved during reverse");
`endif

endmodule

`default_nettype wire
